@@ sv/hla_pkg.sv @@
// Shared types, constants and tag helpers for the implicit-list heap allocator.
package hla_pkg;

    localparam int WORD_W   = 32;
    localparam int REQ_W    = 16;
    localparam int ADDR_W   = 16;
    localparam int CHUNK_W  = 17;
    localparam int STATUS_W = 2;

    localparam logic [WORD_W-1:0]  DWORD     = 32'd8;
    localparam logic [WORD_W-1:0]  WORDB     = 32'd4;
    localparam logic [WORD_W-1:0]  MIN_BLOCK = 32'd16;
    localparam logic [WORD_W-1:0]  ALLOC_BIT = 32'd1;
    localparam logic [CHUNK_W-1:0] RESET_CHUNK = 17'd4096;
    localparam logic [WORD_W-1:0]  RESET_BREAK = 32'd4112;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_ZERO_SIZE = 2'd1,
        ST_EXHAUSTED = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } mode_t;

    // Strip the allocated bit and the spare low bits from a tag.
    function automatic word_t tag_size(input word_t tag);
        tag_size = {tag[WORD_W-1:3], 3'b000};
    endfunction

endpackage

@@ sv/hla_alu.sv @@
// Shared 32-bit add/subtract unit for walk, grow, merge and placement.
module hla_alu
    import hla_pkg::*;
(
    input  word_t a,
    input  word_t b,
    input  logic  sub,
    output word_t y,
    output logic  carry
);

    logic [WORD_W:0] full;

    always_comb
    begin
        if (sub)
        begin
            full = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            full = {1'b0, a} + {1'b0, b};
        end
    end

    assign y     = full[WORD_W-1:0];
    assign carry = full[WORD_W];

endmodule

@@ sv/hla_tag_mem.sv @@
// Tag store: one write port and one registered read port, byte-addressed,
// reads outside the heap return zero and writes there are dropped.
module hla_tag_mem
    import hla_pkg::*;
#(
    parameter int HEAP_BYTES = 65536
)
(
    input  logic  clk,
    input  logic  rd_en,
    input  word_t rd_addr,
    output word_t rd_data,
    input  logic  wr_en,
    input  word_t wr_addr,
    input  word_t wr_data
);

    localparam int DEPTH = HEAP_BYTES / 4;
    localparam int AW    = $clog2(DEPTH);
    localparam word_t LIMIT = WORD_W'(HEAP_BYTES);

    word_t mem [DEPTH];
    word_t q_reg;
    logic  oob_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr < LIMIT))
        begin
            mem[wr_addr[AW+1:2]] <= wr_data;
        end
        if (rd_en)
        begin
            oob_reg <= !(rd_addr < LIMIT);
            q_reg   <= mem[rd_addr[AW+1:2]];
        end
    end

    assign rd_data = oob_reg ? '0 : q_reg;

endmodule

@@ sv/implicit_list_heap_allocator.sv @@
// Implicit-list heap allocator: first-fit walk over boundary-tagged blocks.
//
// The block manages a HEAP_BYTES byte heap held as 32-bit tag words in a
// single-port-read, single-port-write memory. Each input word is either an
// allocate request (s_tuser = 0, size in s_tdata[15:0]) or a free request
// (s_tuser = 1, payload offset in s_tdata[31:16]); each produces exactly one
// output word with the payload offset of the new block (0 if none) and a
// status (0 done, 1 zero-size request, 2 heap exhausted). One request is in
// work at a time and s_tready is low meanwhile. Every tag read goes through
// the one memory read port, which is registered, and most size and pointer
// sums of the walk, the extension, the merge and the placement go through one
// shared adder, so timing is set by the memory. An allocate walks the blocks
// first fit, then places the block and loads the result; when the heap must
// grow, the extension and coalescing come between the walk and the placement.
// A free clears the allocated bit in both tags and coalesces; a zero-size
// request or a free of address zero goes straight to the result. A finished
// word sits in the output register, so a stalled consumer only holds the
// next request at its end. After reset the block sweeps all HEAP_BYTES/4
// words of the tag memory, one word per cycle, writing the prologue, the
// initial free chunk and the epilogue, and takes no request until done. The
// user must write the chunk_bytes register through cfg_valid/cfg_data while
// idle; the block itself does not enforce this.
module implicit_list_heap_allocator
    import hla_pkg::*;
#(
    parameter int HEAP_BYTES = 65536
)
(
    input  logic               clk,
    input  logic               rst_n,
    // config write: chunk_bytes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CHUNK_W-1:0] cfg_data,
    // request stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // request_bytes[15:0], block_address[31:16]
    input  logic               s_tuser,   // mode
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata    // result_address[15:0], status[17:16], zeros
);

    localparam int    DEPTH = HEAP_BYTES / 4;
    localparam int    AW    = $clog2(DEPTH);
    localparam word_t LIMIT = WORD_W'(HEAP_BYTES);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    typedef enum logic [23:0] {
        S_CLEAR  = 24'h000001,
        S_IDLE   = 24'h000002,
        S_FF_CHK = 24'h000004,
        S_GROW   = 24'h000008,
        S_GR_W1  = 24'h000010,
        S_GR_W2  = 24'h000020,
        S_MG0    = 24'h000040,
        S_MG1    = 24'h000080,
        S_MG2    = 24'h000100,
        S_MG3    = 24'h000200,
        S_MG4    = 24'h000400,
        S_MG5    = 24'h000800,
        S_MGA_W2 = 24'h001000,
        S_MGB_W2 = 24'h002000,
        S_MGC1   = 24'h004000,
        S_MGC2   = 24'h008000,
        S_MG_RET = 24'h010000,
        S_PL_RD  = 24'h020000,
        S_PL_DEC = 24'h040000,
        S_PL_S2  = 24'h080000,
        S_PL_S3  = 24'h100000,
        S_PL_S4  = 24'h200000,
        S_PL_N2  = 24'h400000,
        S_FIN    = 24'h800000
    } state_t;

    typedef enum logic [2:0] {
        FR_HDR  = 3'b001,
        FR_W2   = 3'b010,
        FR_NONE = 3'b100
    } free_step_t;

    state_t             st_reg, st_next;
    free_step_t         fr_reg, fr_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;
    word_t              brk_reg, brk_next;
    logic               free_reg, free_next;
    word_t              bp_reg, bp_next;
    word_t              sz_reg, sz_next;
    word_t              asz_reg, asz_next;
    word_t              pb_reg, pb_next;
    word_t              nb_reg, nb_next;
    word_t              t2s_reg, t2s_next;
    word_t              nsz_reg, nsz_next;
    logic               pa_reg, pa_next;
    word_t              res_reg, res_next;
    status_t            stat_reg, stat_next;
    logic               m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]  m_addr_reg, m_addr_next;
    status_t            m_stat_reg, m_stat_next;

    logic  rd_en, wr_en;
    word_t rd_addr, wr_addr, wr_data, rdata, rsize;
    word_t alu_a, alu_b, alu_y;
    logic  alu_sub, alu_carry;

    logic [REQ_W-1:0]   req;
    logic [ADDR_W-1:0]  addr;
    logic [CHUNK_W-1:0] ext;
    word_t              asz_new, szg;

    hla_tag_mem #(.HEAP_BYTES(HEAP_BYTES)) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rdata),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    hla_alu u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .y     (alu_y),
        .carry (alu_carry)
    );

    function automatic logic in_heap(input word_t a);
        in_heap = a < LIMIT;
    endfunction

    // Reset image of a tag word: prologue, initial chunk tags, epilogue.
    function automatic word_t init_word(input logic [AW-1:0] i);
        word_t v;
        v = '0;
        if ((i == AW'(1)) || (i == AW'(2)))
        begin
            v = DWORD | ALLOC_BIT;
        end
        else if ((i == AW'(3)) || (i == AW'(1026)))
        begin
            v = WORD_W'(RESET_CHUNK);
        end
        else if (i == AW'(1027))
        begin
            v = ALLOC_BIT;
        end
        init_word = v;
    endfunction

    assign req   = s_tdata[15:0];
    assign addr  = s_tdata[31:16];
    assign rsize = tag_size(rdata);

    // Round the request to a double-word block with room for both tags.
    assign asz_new = (req <= REQ_W'(8)) ? MIN_BLOCK
                   : ((WORD_W'(req) + 32'd15) & ~32'd7);
    // Extension: max(size, chunk), rounded to an even number of words.
    assign ext = (asz_reg[CHUNK_W-1:0] > chunk_reg) ? asz_reg[CHUNK_W-1:0] : chunk_reg;
    assign szg = ((WORD_W'(ext) & ~32'd3) + WORDB) & ~32'd7;

    // Operand select for the shared adder.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (st_reg)
            S_FF_CHK:
            begin
                alu_a = bp_reg;
                alu_b = rsize;
            end
            S_GROW:
            begin
                alu_a = brk_reg;
                alu_b = szg;
            end
            S_GR_W1,
            S_GR_W2:
            begin
                alu_a = bp_reg;
                alu_b = sz_reg;
            end
            S_MG1:
            begin
                alu_a   = bp_reg;
                alu_b   = rsize;
                alu_sub = 1'b1;
            end
            S_MG2:
            begin
                alu_a = pb_reg;
                alu_b = rsize;
            end
            S_MG4:
            begin
                alu_a = bp_reg;
                alu_b = rsize;
            end
            S_MG5:
            begin
                alu_a = sz_reg;
                alu_b = pa_reg ? tag_size(rdata) : t2s_reg;
            end
            S_MGC1:
            begin
                alu_a = sz_reg;
                alu_b = rsize;
            end
            S_PL_DEC:
            begin
                alu_a   = rsize;
                alu_b   = asz_reg;
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        st_next      = st_reg;
        fr_next      = fr_reg;
        idx_next     = idx_reg;
        chunk_next   = chunk_reg;
        brk_next     = brk_reg;
        free_next    = free_reg;
        bp_next      = bp_reg;
        sz_next      = sz_reg;
        asz_next     = asz_reg;
        pb_next      = pb_reg;
        nb_next      = nb_reg;
        t2s_next     = t2s_reg;
        nsz_next     = nsz_reg;
        pa_next      = pa_reg;
        res_next     = res_reg;
        stat_next    = stat_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        m_addr_next  = m_addr_reg;
        m_stat_next  = m_stat_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;

        if (cfg_valid)
        begin
            chunk_next = cfg_data;
        end

        case (st_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = WORD_W'(idx_reg) << 2;
                wr_data  = init_word(idx_reg);
                idx_next = idx_reg + AW'(1);
                if (idx_reg == LAST_IDX)
                begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_next  = '0;
                    stat_next = ST_DONE;
                    if (s_tuser == MODE_FREE)
                    begin
                        free_next = 1'b1;
                        bp_next   = WORD_W'(addr);
                        if (addr == '0)
                        begin
                            st_next = S_FIN;
                        end
                        else
                        begin
                            rd_en   = 1'b1;
                            rd_addr = WORD_W'(addr) - WORDB;
                            fr_next = FR_HDR;
                            st_next = S_PL_RD;
                        end
                    end
                    else if (req == '0)
                    begin
                        stat_next = ST_ZERO_SIZE;
                        st_next   = S_FIN;
                    end
                    else
                    begin
                        free_next = 1'b0;
                        fr_next   = FR_NONE;
                        asz_next  = asz_new;
                        bp_next   = DWORD;
                        rd_en     = 1'b1;
                        rd_addr   = WORDB;
                        st_next   = S_FF_CHK;
                    end
                end
            end
            S_FF_CHK:
            begin
                if (rsize == '0)
                begin
                    st_next = S_GROW;
                end
                else if (!rdata[0] && (asz_reg <= rsize))
                begin
                    rd_en   = 1'b1;
                    rd_addr = bp_reg - WORDB;
                    st_next = S_PL_DEC;
                end
                else if (alu_carry)
                begin
                    st_next = S_GROW;
                end
                else
                begin
                    bp_next = alu_y;
                    rd_en   = 1'b1;
                    rd_addr = alu_y - WORDB;
                end
            end
            S_GROW:
            begin
                if (alu_y > LIMIT)
                begin
                    stat_next = ST_EXHAUSTED;
                    st_next   = S_FIN;
                end
                else
                begin
                    bp_next = brk_reg;
                    sz_next = szg;
                    wr_en   = 1'b1;
                    wr_addr = brk_reg - WORDB;
                    wr_data = szg;
                    st_next = S_GR_W1;
                end
            end
            S_GR_W1:
            begin
                wr_en   = 1'b1;
                wr_addr = alu_y - DWORD;
                wr_data = sz_reg;
                st_next = S_GR_W2;
            end
            S_GR_W2:
            begin
                // new epilogue, then move the break
                wr_en    = 1'b1;
                wr_addr  = alu_y - WORDB;
                wr_data  = ALLOC_BIT;
                brk_next = alu_y;
                st_next  = S_MG0;
            end
            S_MG0:
            begin
                rd_en   = 1'b1;
                rd_addr = bp_reg - DWORD;
                st_next = S_MG1;
            end
            S_MG1:
            begin
                pb_next = alu_y;
                rd_en   = 1'b1;
                rd_addr = alu_y - WORDB;
                st_next = S_MG2;
            end
            S_MG2:
            begin
                t2s_next = rsize;
                rd_en    = 1'b1;
                rd_addr  = alu_y - DWORD;
                st_next  = S_MG3;
            end
            S_MG3:
            begin
                pa_next = rdata[0];
                rd_en   = 1'b1;
                rd_addr = bp_reg - WORDB;
                st_next = S_MG4;
            end
            S_MG4:
            begin
                sz_next = rsize;
                nb_next = alu_y;
                rd_en   = 1'b1;
                rd_addr = alu_y - WORDB;
                st_next = S_MG5;
            end
            S_MG5:
            begin
                nsz_next = rsize;
                if (pa_reg && rdata[0])
                begin
                    st_next = S_MG_RET;
                end
                else if (pa_reg)
                begin
                    // absorb the next block
                    sz_next = alu_y;
                    wr_en   = 1'b1;
                    wr_addr = bp_reg - WORDB;
                    wr_data = alu_y;
                    st_next = S_MGA_W2;
                end
                else if (rdata[0])
                begin
                    // absorb into the previous block
                    sz_next = alu_y;
                    wr_en   = 1'b1;
                    wr_addr = nb_reg - DWORD;
                    wr_data = alu_y;
                    st_next = S_MGB_W2;
                end
                else
                begin
                    sz_next = alu_y;
                    rd_en   = 1'b1;
                    rd_addr = nb_reg + rsize - DWORD;
                    st_next = S_MGC1;
                end
            end
            S_MGA_W2:
            begin
                wr_en   = 1'b1;
                wr_addr = bp_reg + (in_heap(bp_reg - WORDB) ? sz_reg : '0) - DWORD;
                wr_data = sz_reg;
                st_next = S_MG_RET;
            end
            S_MGB_W2:
            begin
                wr_en   = 1'b1;
                wr_addr = pb_reg - WORDB;
                wr_data = sz_reg;
                bp_next = pb_reg;
                st_next = S_MG_RET;
            end
            S_MGC1:
            begin
                sz_next = alu_y;
                wr_en   = 1'b1;
                wr_addr = pb_reg - WORDB;
                wr_data = alu_y;
                st_next = S_MGC2;
            end
            S_MGC2:
            begin
                // next header size as left by the previous header write
                wr_en   = 1'b1;
                wr_addr = nb_reg
                        + ((in_heap(pb_reg - WORDB)
                            && ((pb_reg - WORDB) >> 2) == ((nb_reg - WORDB) >> 2))
                           ? sz_reg : nsz_reg)
                        - DWORD;
                wr_data = sz_reg;
                bp_next = pb_reg;
                st_next = S_MG_RET;
            end
            S_MG_RET:
            begin
                if (free_reg)
                begin
                    st_next = S_FIN;
                end
                else if (bp_reg == '0)
                begin
                    stat_next = ST_EXHAUSTED;
                    st_next   = S_FIN;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = bp_reg - WORDB;
                    st_next = S_PL_DEC;
                end
            end
            S_PL_RD:
            begin
                // free path: clear the allocated bit in both tags
                case (fr_reg)
                    FR_HDR:
                    begin
                        sz_next = rsize;
                        wr_en   = 1'b1;
                        wr_addr = bp_reg - WORDB;
                        wr_data = rsize;
                        fr_next = FR_W2;
                    end
                    FR_W2:
                    begin
                        wr_en   = 1'b1;
                        wr_addr = bp_reg + (in_heap(bp_reg - WORDB) ? sz_reg : '0) - DWORD;
                        wr_data = sz_reg;
                        fr_next = FR_NONE;
                        st_next = S_MG0;
                    end
                    default:
                    begin
                        st_next = S_MG0;
                    end
                endcase
            end
            S_PL_DEC:
            begin
                wr_en   = 1'b1;
                wr_addr = bp_reg - WORDB;
                if (alu_y >= MIN_BLOCK)
                begin
                    sz_next = alu_y;
                    wr_data = asz_reg | ALLOC_BIT;
                    st_next = S_PL_S2;
                end
                else
                begin
                    sz_next = rsize;
                    wr_data = rsize | ALLOC_BIT;
                    st_next = S_PL_N2;
                end
            end
            S_PL_S2:
            begin
                wr_en   = 1'b1;
                wr_addr = bp_reg + (in_heap(bp_reg - WORDB) ? asz_reg : '0) - DWORD;
                wr_data = asz_reg | ALLOC_BIT;
                nb_next = bp_reg + (in_heap(bp_reg - WORDB) ? asz_reg : '0);
                st_next = S_PL_S3;
            end
            S_PL_S3:
            begin
                wr_en   = 1'b1;
                wr_addr = nb_reg - WORDB;
                wr_data = sz_reg;
                st_next = S_PL_S4;
            end
            S_PL_S4:
            begin
                wr_en    = 1'b1;
                wr_addr  = nb_reg + (in_heap(nb_reg - WORDB) ? sz_reg : '0) - DWORD;
                wr_data  = sz_reg;
                res_next = bp_reg;
                st_next  = S_FIN;
            end
            S_PL_N2:
            begin
                wr_en    = 1'b1;
                wr_addr  = bp_reg + (in_heap(bp_reg - WORDB) ? sz_reg : '0) - DWORD;
                wr_data  = sz_reg | ALLOC_BIT;
                res_next = bp_reg;
                st_next  = S_FIN;
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_addr_next  = res_reg[ADDR_W-1:0];
                    m_stat_next  = stat_reg;
                    st_next      = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_CLEAR;
            fr_reg      <= FR_NONE;
            idx_reg     <= '0;
            chunk_reg   <= RESET_CHUNK;
            brk_reg     <= RESET_BREAK;
            free_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            fr_reg      <= fr_next;
            idx_reg     <= idx_next;
            chunk_reg   <= chunk_next;
            brk_reg     <= brk_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bp_reg     <= bp_next;
        sz_reg     <= sz_next;
        asz_reg    <= asz_next;
        pb_reg     <= pb_next;
        nb_reg     <= nb_next;
        t2s_reg    <= t2s_next;
        nsz_reg    <= nsz_next;
        pa_reg     <= pa_next;
        res_reg    <= res_next;
        stat_reg   <= stat_next;
        m_addr_reg <= m_addr_next;
        m_stat_reg <= m_stat_next;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (st_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'b0, m_stat_reg, m_addr_reg};

    // The break never moves past the end of the heap.
    a_brk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        brk_reg <= LIMIT)
        else $error("break offset beyond heap");

    // No request is taken during the clearing sweep.
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_CLEAR) |-> !s_tready)
        else $error("request accepted during clear");

    // A finished request with a free output register shows its result next.
    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((st_reg == S_FIN) && !m_valid_reg) |=> m_valid_reg)
        else $error("result not delivered");

    // A delivered word never carries an undefined status.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_stat_reg != 2'd3))
        else $error("bad status code");

    // A nonzero address only comes with a completed allocation.
    a_addr_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_addr_reg != '0)) |-> (m_stat_reg == ST_DONE))
        else $error("address with failure status");

endmodule

@@ tb/implicit_list_heap_allocator_tb.sv @@
// Self-checking testbench for the implicit-list heap allocator.
`timescale 1ns / 1ps

module implicit_list_heap_allocator_tb;
    import hla_pkg::*;

    localparam int HEAP = 65536;
    localparam int TAGS = HEAP / 4;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] req_bytes;
        logic [15:0] blk_addr;
    } request_t;

    typedef struct packed {
        logic [15:0] addr;
        status_t     status;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [16:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    implicit_list_heap_allocator #(.HEAP_BYTES(HEAP)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Shadow heap: tag words, break and chunk size, as the block should hold them.
    logic [31:0] heap_tags [TAGS];
    logic [31:0] heap_break;
    logic [31:0] heap_chunk;

    request_t pending_reqs [$];
    outcome_t expected_outcomes [$];
    // Payload offsets currently allocated, used to pick sensible frees.
    logic [15:0] live_blocks [$];

    int  errors;
    int  idle_cycles;
    bit  stim_done;

    // ---------------- shadow heap helpers ----------------
    function automatic logic [31:0] tag_rd(logic [31:0] a);
        if ((a >> 2) >= TAGS) return 32'd0;
        return heap_tags[a >> 2];
    endfunction

    function automatic void tag_wr(logic [31:0] a, logic [31:0] v);
        if ((a >> 2) < TAGS) heap_tags[a >> 2] = v;
    endfunction

    function automatic logic [31:0] sz_at(logic [31:0] a);
        return tag_rd(a) & ~32'h7;
    endfunction

    function automatic logic [31:0] used_at(logic [31:0] a);
        return tag_rd(a) & 32'h1;
    endfunction

    function automatic logic [31:0] foot_of(logic [31:0] bp);
        return bp + sz_at(bp - 4) - 8;
    endfunction

    function automatic logic [31:0] succ_of(logic [31:0] bp);
        return bp + sz_at(bp - 4);
    endfunction

    function automatic logic [31:0] pred_of(logic [31:0] bp);
        return bp - sz_at(bp - 8);
    endfunction

    function automatic logic [31:0] coalesce(logic [31:0] bp);
        logic [31:0] pa, na, sz, p, n;
        pa = used_at(foot_of(pred_of(bp)));
        na = used_at(succ_of(bp) - 4);
        sz = sz_at(bp - 4);
        if (pa != 0 && na != 0) return bp;
        if (pa != 0)
        begin
            sz = sz + sz_at(succ_of(bp) - 4);
            tag_wr(bp - 4, sz);
            tag_wr(foot_of(bp), sz);
            return bp;
        end
        if (na != 0)
        begin
            p = pred_of(bp);
            sz = sz + sz_at(p - 4);
            tag_wr(foot_of(bp), sz);
            tag_wr(p - 4, sz);
            return p;
        end
        p = pred_of(bp);
        n = succ_of(bp);
        sz = sz + sz_at(p - 4) + sz_at(foot_of(n));
        tag_wr(p - 4, sz);
        tag_wr(foot_of(n), sz);
        return p;
    endfunction

    function automatic logic [31:0] grow_heap(logic [31:0] bytes);
        logic [31:0] w, sz, bp;
        w = bytes >> 2;
        if (w[0]) w = w + 1;
        sz = w * 4;
        if ({32'd0, heap_break} + {32'd0, sz} > 64'(HEAP)) return 32'd0;
        bp = heap_break;
        tag_wr(bp - 4, sz);
        tag_wr(foot_of(bp), sz);
        tag_wr(succ_of(bp) - 4, 32'd1);
        heap_break = heap_break + sz;
        return coalesce(bp);
    endfunction

    function automatic logic [31:0] find_fit(logic [31:0] asize);
        logic [31:0] bp, s;
        bp = 8;
        forever
        begin
            s = sz_at(bp - 4);
            if (s == 0) return 32'd0;
            if (used_at(bp - 4) == 0 && asize <= s) return bp;
            if (bp + s <= bp) return 32'd0;
            bp = bp + s;
        end
    endfunction

    function automatic void carve(logic [31:0] bp, logic [31:0] asize);
        logic [31:0] cs;
        cs = sz_at(bp - 4);
        if (cs - asize >= 16)
        begin
            tag_wr(bp - 4, asize | 1);
            tag_wr(foot_of(bp), asize | 1);
            bp = succ_of(bp);
            tag_wr(bp - 4, cs - asize);
            tag_wr(foot_of(bp), cs - asize);
        end
        else
        begin
            tag_wr(bp - 4, cs | 1);
            tag_wr(foot_of(bp), cs | 1);
        end
    endfunction

    function automatic void heap_reset();
        logic [31:0] unused;
        foreach (heap_tags[i]) heap_tags[i] = 32'd0;
        heap_chunk = 4096;
        tag_wr(4, 32'd9);
        tag_wr(8, 32'd9);
        tag_wr(12, 32'd1);
        heap_break = 16;
        unused = grow_heap(32'd4096);
    endfunction

    // Work out the outcome of one request and advance the shadow heap.
    function automatic outcome_t serve_request(request_t r);
        outcome_t o;
        logic [31:0] asize, bp, ext, sz;
        o.addr = 16'd0;
        o.status = ST_DONE;
        if (r.mode == MODE_ALLOC)
        begin
            if (r.req_bytes == 0)
            begin
                o.status = ST_ZERO_SIZE;
            end
            else
            begin
                asize = (r.req_bytes <= 8) ? 32'd16
                    : 8 * ((32'(r.req_bytes) + 15) / 8);
                bp = find_fit(asize);
                if (bp == 0)
                begin
                    ext = (asize > heap_chunk) ? asize : heap_chunk;
                    bp = grow_heap(ext);
                end
                if (bp == 0)
                begin
                    o.status = ST_EXHAUSTED;
                end
                else
                begin
                    carve(bp, asize);
                    o.addr = bp[15:0];
                end
            end
        end
        else if (r.blk_addr != 0)
        begin
            sz = sz_at(32'(r.blk_addr) - 4);
            tag_wr(32'(r.blk_addr) - 4, sz);
            tag_wr(foot_of(32'(r.blk_addr)), sz);
            void'(coalesce(32'(r.blk_addr)));
        end
        return o;
    endfunction

    // ---------------- clock and reset ----------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---------------- request driver ----------------
    int        send_gap;
    request_t  cur_req;
    bit        hold_sends;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                // Predict at acceptance so the shadow heap tracks the block's order.
                expected_outcomes.push_back(serve_request(cur_req));
            end
            if (s_tvalid && !s_tready)
            begin
                // hold the word
            end
            else if (send_gap > 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (!hold_sends && pending_reqs.size() > 0)
            begin
                cur_req  = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= cur_req.mode;
                s_tdata  <= {cur_req.blk_addr, cur_req.req_bytes};
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- result monitor ----------------
    int recv_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected word addr=%0d status=%0d",
                             $time, m_tdata[15:0], m_tdata[17:16]);
                    errors++;
                end
                else
                begin
                    outcome_t e;
                    e = expected_outcomes.pop_front();
                    if (m_tdata[15:0] !== e.addr)
                    begin
                        $display("%0t: result_address expected %0d actual %0d",
                                 $time, e.addr, m_tdata[15:0]);
                        errors++;
                    end
                    if (m_tdata[17:16] !== e.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, m_tdata[17:16]);
                        errors++;
                    end
                end
                // draw a fresh stall for the next word
                recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
                m_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge clk)
    begin
        if (rst_n && !stim_done)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic request_t alloc_req(logic [15:0] n);
        request_t r;
        r.mode = MODE_ALLOC;
        r.req_bytes = n;
        r.blk_addr = 16'($urandom());
        return r;
    endfunction

    function automatic request_t free_req(logic [15:0] a);
        request_t r;
        r.mode = MODE_FREE;
        r.req_bytes = 16'($urandom());
        r.blk_addr = a;
        return r;
    endfunction

    // Wait until the block has returned every expected word, then let it settle.
    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_outcomes.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_chunk(logic [16:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        heap_chunk = 32'(v);
    endtask

    initial
    begin
        int ph, j;
        logic [16:0] chunk_set [5];
        errors = 0;
        idle_cycles = 0;
        stim_done = 0;
        hold_sends = 0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        heap_reset();
        chunk_set[0] = 17'd8;
        chunk_set[1] = 17'd65536;
        chunk_set[2] = 17'd4096;
        chunk_set[3] = 17'd200;
        chunk_set[4] = 17'd131071;
        @(posedge rst_n);

        // Directed: extremes, both modes, zero-size, free of zero, exhaustion.
        pending_reqs.push_back(alloc_req(16'd0));
        pending_reqs.push_back(alloc_req(16'd1));
        pending_reqs.push_back(alloc_req(16'd8));
        pending_reqs.push_back(alloc_req(16'd9));
        pending_reqs.push_back(free_req(16'd0));
        pending_reqs.push_back(free_req(16'd16));
        pending_reqs.push_back(free_req(16'd32));
        pending_reqs.push_back(alloc_req(16'd4000));
        pending_reqs.push_back(alloc_req(16'd65535));
        pending_reqs.push_back(alloc_req(16'd30000));
        pending_reqs.push_back(alloc_req(16'd30000));
        pending_reqs.push_back(free_req(16'hFFFF));
        pending_reqs.push_back(free_req(16'd8));
        pending_reqs.push_back(free_req(16'd24));
        drain();

        for (ph = 0; ph < 5; ph++)
        begin
            write_chunk(chunk_set[ph]);
            for (j = 0; j < 330; j++)
            begin
                request_t r;
                int pick;
                pick = $urandom_range(0, 99);
                if (pick < 50 || live_blocks.size() == 0)
                begin
                    r = alloc_req(($urandom_range(0, 15) == 0) ? 16'($urandom())
                                  : 16'($urandom_range(1, 400)));
                end
                else if (pick < 92)
                begin
                    int idx;
                    idx = $urandom_range(0, live_blocks.size() - 1);
                    r = free_req(live_blocks[idx]);
                    live_blocks.delete(idx);
                end
                else if (pick < 96)
                begin
                    r = free_req(16'd0);
                end
                else
                begin
                    r = alloc_req(16'd0);
                end
                pending_reqs.push_back(r);
                // Feed one at a time so granted addresses are known before frees.
                while (pending_reqs.size() > 0 || s_tvalid) @(posedge clk);
                if (r.mode == MODE_ALLOC && expected_outcomes.size() > 0
                    && expected_outcomes[$].addr != 0)
                    live_blocks.push_back(expected_outcomes[$].addr);
                if (j == 150)
                begin
                    // Hold off the sender until the block has caught up.
                    hold_sends = 1;
                    while (expected_outcomes.size() > 0) @(posedge clk);
                    hold_sends = 0;
                end
            end
            drain();
            // Free everything back so later phases start with no live blocks.
            while (live_blocks.size() > 0)
                pending_reqs.push_back(free_req(live_blocks.pop_front()));
            drain();
        end

        drain();
        stim_done = 1;
        if (errors == 0 && expected_outcomes.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
